// ===== hw/rtl/chkv_pkg.sv =====
`default_nettype none
package chkv_pkg;
   localparam int KEY_W = 31;
   localparam int VAL_W = 32;
   localparam int CNT_W = 11;
   localparam int OP_W  = 2;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;
   localparam logic [OP_W-1:0] OP_RANGE  = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]         operation;
      logic [KEY_W-1:0]        key;
      logic signed [VAL_W-1:0] value;
      logic [KEY_W-1:0]        range_end;
   } req_type;

   typedef struct packed {
      logic                    found;
      logic signed [VAL_W-1:0] found_value;
      logic                    status;
      logic [CNT_W-1:0]        range_count;
      logic [CNT_W-1:0]        stored_count;
   } rsp_type;
endpackage
`default_nettype wire

// ===== hw/rtl/chkv_ram.sv =====
`default_nettype none
module chkv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// ===== hw/rtl/chkv_mod.sv =====
`default_nettype none
module chkv_mod #(
   parameter int BUCKETS = 1024
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [chkv_pkg::KEY_W-1:0]  key,
   output logic                             done,
   output logic [$clog2(BUCKETS)-1:0]       bucket
);
   localparam int BIW = $clog2(BUCKETS);
   localparam int SH  = chkv_pkg::KEY_W + BIW;
   localparam int PW  = chkv_pkg::KEY_W + 32;
   localparam logic [31:0] RECIP =
      32'(((64'd1 << SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

   logic                       step_ff, step_in;
   logic                       done_ff, done_in;
   logic [chkv_pkg::KEY_W-1:0] key_ff, key_in;
   logic [PW-1:0]              prod_ff, prod_in;
   logic [BIW-1:0]             rem_ff, rem_in;
   logic [BIW-1:0]             quot_lo;

   // quotient by rounded-up reciprocal, exact for every 31-bit key;
   // only the low bucket-index bits of quotient times BUCKETS matter
   always_comb begin
      quot_lo = BIW'(prod_ff >> SH);
      step_in = start;
      done_in = step_ff;
      key_in  = key_ff;
      prod_in = prod_ff;
      rem_in  = rem_ff;
      if (start) begin
         key_in  = key;
         prod_in = {32'd0, key} * {{chkv_pkg::KEY_W{1'b0}}, RECIP};
      end
      if (step_ff) begin
         rem_in = key_ff[BIW-1:0] - BIW'(quot_lo * BIW'(BUCKETS));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
      key_ff  <= key_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
   end

   assign done   = done_ff;
   assign bucket = rem_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/chained_hash_key_value_store.sv =====
// chained hash key/value store
// req channel (valid/ready): operation, key, value, range_end. rsp channel
// (valid/ready): found, found_value, status, range_count, stored_count; one
// response per request, in order.
// one request is worked at a time; req_ready is high only while the sequencer
// is idle. a request first takes the key modulo BUCKETS by a reciprocal
// multiply and a subtract, then walks the bucket chain through the node
// memory at one node per cycle, followed by bookkeeping. a range count walks
// every node ever allocated, one node per cycle through the same memory port.
// the response sits in an output register; the next request is taken while
// it waits, and the sequencer holds its result only when a second one is
// ready before the first is taken.
// after reset a clearing pass writes every bucket head empty, one per cycle,
// with req_ready low.
`default_nettype none
module chained_hash_key_value_store #(
   parameter int BUCKETS = 1024,
   parameter int NODES   = 1024
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire chkv_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output chkv_pkg::rsp_type      rsp_data
);
   localparam int BIW = $clog2(BUCKETS);
   localparam int NIW = $clog2(NODES);
   localparam int NW  = $clog2(NODES + 1);
   localparam logic [NW-1:0] NULL_NODE = NW'(NODES);

   typedef struct packed {
      logic                         in_use;
      logic [NW-1:0]                next;
      logic [chkv_pkg::VAL_W-1:0]   value;
      logic [chkv_pkg::KEY_W-1:0]   key;
   } node_type;
   localparam int NWORD = $bits(node_type);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_MOD   = 4'd2;
   localparam logic [3:0] S_HEAD  = 4'd3;
   localparam logic [3:0] S_NODE  = 4'd4;
   localparam logic [3:0] S_REM   = 4'd5;
   localparam logic [3:0] S_ALLOC = 4'd6;
   localparam logic [3:0] S_SCAN  = 4'd7;
   localparam logic [3:0] S_DONE  = 4'd8;

   logic [3:0]        state_ff, state_in;
   logic [BIW-1:0]    clr_ff, clr_in;
   chkv_pkg::req_type req_ff, req_in;
   logic [BIW-1:0]    bkt_ff, bkt_in;
   logic [NW-1:0]     head_ff, head_in;
   logic [NW-1:0]     cur_ff, cur_in;
   logic [NW-1:0]     prev_ff, prev_in;
   node_type          prev_word_ff, prev_word_in;
   node_type          node_word_ff, node_word_in;
   logic [NW-1:0]     steps_ff, steps_in;
   logic [NW-1:0]     free_top_ff, free_top_in;
   logic [NW-1:0]     never_ff, never_in;
   logic [NW-1:0]     entry_ff, entry_in;
   logic              use_free_ff, use_free_in;
   logic [NW-1:0]     fresh_ff, fresh_in;
   logic [NW-1:0]     scan_idx_ff, scan_idx_in;
   logic              pend_ff, pend_in;
   chkv_pkg::rsp_type res_ff, res_in;
   chkv_pkg::rsp_type rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              b_we;
   logic [BIW-1:0]    b_waddr, b_raddr;
   logic [NW-1:0]     b_wdata, b_rdata;
   logic              n_we;
   logic [NIW-1:0]    n_waddr, n_raddr;
   logic [NWORD-1:0]  n_wdata, n_rdata;
   logic              f_we;
   logic [NIW-1:0]    f_waddr, f_raddr;
   logic [NIW-1:0]    f_wdata, f_rdata;

   logic              mod_start, mod_done;
   logic [BIW-1:0]    mod_bucket;

   chkv_ram #(.WIDTH(NW), .DEPTH(BUCKETS)) u_bucket_ram (
      .clock(clock), .wr_en(b_we), .wr_addr(b_waddr), .wr_data(b_wdata),
      .rd_addr(b_raddr), .rd_data(b_rdata)
   );

   chkv_ram #(.WIDTH(NWORD), .DEPTH(NODES)) u_node_ram (
      .clock(clock), .wr_en(n_we), .wr_addr(n_waddr), .wr_data(n_wdata),
      .rd_addr(n_raddr), .rd_data(n_rdata)
   );

   chkv_ram #(.WIDTH(NIW), .DEPTH(NODES)) u_free_ram (
      .clock(clock), .wr_en(f_we), .wr_addr(f_waddr), .wr_data(f_wdata),
      .rd_addr(f_raddr), .rd_data(f_rdata)
   );

   chkv_mod #(.BUCKETS(BUCKETS)) u_mod (
      .clock(clock), .reset(reset), .start(mod_start), .key(req_ff.key),
      .done(mod_done), .bucket(mod_bucket)
   );

   always_comb begin
      node_type nd;
      node_type wr;
      logic     miss;
      logic [NW-1:0] fresh;

      nd    = node_type'(n_rdata);
      wr    = nd;
      miss  = 1'b0;
      fresh = fresh_ff;

      state_in     = state_ff;
      clr_in       = clr_ff;
      req_in       = req_ff;
      bkt_in       = bkt_ff;
      head_in      = head_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      prev_word_in = prev_word_ff;
      node_word_in = node_word_ff;
      steps_in     = steps_ff;
      free_top_in  = free_top_ff;
      never_in     = never_ff;
      entry_in     = entry_ff;
      use_free_in  = use_free_ff;
      fresh_in     = fresh_ff;
      scan_idx_in  = scan_idx_ff;
      pend_in      = pend_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      b_we = 1'b0; b_waddr = bkt_ff; b_wdata = NULL_NODE; b_raddr = bkt_ff;
      n_we = 1'b0; n_waddr = cur_ff[NIW-1:0]; n_wdata = NWORD'(nd);
      n_raddr = cur_ff[NIW-1:0];
      f_we = 1'b0; f_waddr = free_top_ff[NIW-1:0]; f_wdata = cur_ff[NIW-1:0];
      f_raddr = free_top_ff[NIW-1:0];
      mod_start = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            b_we    = 1'b1;
            b_waddr = clr_ff;
            b_wdata = NULL_NODE;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == BIW'(BUCKETS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               res_in = '0;
               if (req_data.operation == chkv_pkg::OP_RANGE) begin
                  scan_idx_in = '0;
                  pend_in     = 1'b0;
                  state_in    = S_SCAN;
               end else begin
                  state_in = S_MOD;
               end
            end
         end
         S_MOD: begin
            // start pulses on the first cycle here; done cannot be high yet
            mod_start = !mod_done && (steps_ff != NULL_NODE);
            steps_in  = NULL_NODE;
            if (mod_done) begin
               bkt_in   = mod_bucket;
               b_raddr  = mod_bucket;
               state_in = S_HEAD;
            end
         end
         S_HEAD: begin
            head_in  = b_rdata;
            cur_in   = b_rdata;
            prev_in  = NULL_NODE;
            steps_in = '0;
            if (b_rdata == NULL_NODE) begin
               miss = 1'b1;
            end else begin
               n_raddr  = b_rdata[NIW-1:0];
               state_in = S_NODE;
            end
         end
         S_NODE: begin
            if (nd.key == req_ff.key) begin
               res_in.found = 1'b1;
               state_in     = S_DONE;
               case (req_ff.operation)
                  chkv_pkg::OP_INSERT: begin
                     wr.value = req_ff.value;
                     n_we     = 1'b1;
                     n_waddr  = cur_ff[NIW-1:0];
                     n_wdata  = NWORD'(wr);
                  end
                  chkv_pkg::OP_LOOKUP: begin
                     res_in.found_value = nd.value;
                  end
                  chkv_pkg::OP_REMOVE: begin
                     node_word_in = nd;
                     if (prev_ff == NULL_NODE) begin
                        b_we    = 1'b1;
                        b_waddr = bkt_ff;
                        b_wdata = nd.next;
                     end else begin
                        wr      = prev_word_ff;
                        wr.next = nd.next;
                        n_we    = 1'b1;
                        n_waddr = prev_ff[NIW-1:0];
                        n_wdata = NWORD'(wr);
                     end
                     if (free_top_ff != NULL_NODE) begin
                        f_we        = 1'b1;
                        f_waddr     = free_top_ff[NIW-1:0];
                        f_wdata     = cur_ff[NIW-1:0];
                        free_top_in = free_top_ff + 1'b1;
                     end
                     if (entry_ff != '0) begin
                        entry_in = entry_ff - 1'b1;
                     end
                     state_in = S_REM;
                  end
                  default: begin
                  end
               endcase
            end else begin
               prev_in      = cur_ff;
               prev_word_in = nd;
               cur_in       = nd.next;
               steps_in     = steps_ff + 1'b1;
               if (nd.next == NULL_NODE || steps_ff == NW'(NODES - 1)) begin
                  miss = 1'b1;
               end else begin
                  n_raddr = nd.next[NIW-1:0];
               end
            end
         end
         S_REM: begin
            wr        = node_word_ff;
            wr.in_use = 1'b0;
            n_we      = 1'b1;
            n_waddr   = cur_ff[NIW-1:0];
            n_wdata   = NWORD'(wr);
            state_in  = S_DONE;
         end
         S_ALLOC: begin
            fresh = use_free_ff ? NW'(f_rdata) : fresh_ff;
            wr.in_use = 1'b1;
            wr.next   = head_ff;
            wr.value  = req_ff.value;
            wr.key    = req_ff.key;
            n_we      = 1'b1;
            n_waddr   = fresh[NIW-1:0];
            n_wdata   = NWORD'(wr);
            b_we      = 1'b1;
            b_waddr   = bkt_ff;
            b_wdata   = fresh;
            entry_in  = entry_ff + 1'b1;
            state_in  = S_DONE;
         end
         S_SCAN: begin
            // issue one pool read per cycle, check the one from last cycle
            pend_in = 1'b0;
            if (scan_idx_ff != never_ff) begin
               n_raddr     = scan_idx_ff[NIW-1:0];
               scan_idx_in = scan_idx_ff + 1'b1;
               pend_in     = 1'b1;
            end
            if (pend_ff && nd.in_use && nd.key >= req_ff.key
                && nd.key <= req_ff.range_end) begin
               res_in.range_count = res_ff.range_count + 1'b1;
            end
            if (scan_idx_ff == never_ff && !pend_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in              = res_ff;
               rsp_in.stored_count = chkv_pkg::CNT_W'(entry_ff);
               rsp_valid_in        = 1'b1;
               state_in            = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // key absent: insert takes a node (or reports status when the pool is full), other operations just finish
      if (miss) begin
         state_in = S_DONE;
         if (req_ff.operation == chkv_pkg::OP_INSERT) begin
            if (free_top_ff != '0) begin
               f_raddr     = NIW'(free_top_ff - 1'b1);
               free_top_in = free_top_ff - 1'b1;
               use_free_in = 1'b1;
               state_in    = S_ALLOC;
            end else if (never_ff != NULL_NODE) begin
               fresh_in    = never_ff;
               never_in    = never_ff + 1'b1;
               use_free_in = 1'b0;
               state_in    = S_ALLOC;
            end else begin
               res_in.status = 1'b1;
            end
         end
      end

      // steps doubles as the start-issued mark while in the modulo state
      if (state_ff == S_IDLE) begin
         steps_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         free_top_ff  <= '0;
         never_ff     <= '0;
         entry_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         free_top_ff  <= free_top_in;
         never_ff     <= never_in;
         entry_ff     <= entry_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff       <= req_in;
      bkt_ff       <= bkt_in;
      head_ff      <= head_in;
      cur_ff       <= cur_in;
      prev_ff      <= prev_in;
      prev_word_ff <= prev_word_in;
      node_word_ff <= node_word_in;
      steps_ff     <= steps_in;
      use_free_ff  <= use_free_in;
      fresh_ff     <= fresh_in;
      scan_idx_ff  <= scan_idx_in;
      res_ff       <= res_in;
      rsp_ff       <= rsp_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/chkv_checker.sv =====
`default_nettype none
module chkv_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire chkv_pkg::rsp_type rsp_data
);
   // a stalled response holds its transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // a dropped insert reports nothing else
   a_status_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status |->
         !rsp_data.found && rsp_data.found_value == '0 && rsp_data.range_count == '0)
      else $error("pool-full response carries other fields");

   // the clearing pass keeps requests out right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("ready during clearing pass");

   // one request at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");
endmodule

bind chained_hash_key_value_store chkv_checker u_chkv_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data(rsp_data)
);
`default_nettype wire
